// ===== rtl/brw_pkg.sv =====
// brw_pkg: operation codes, read kinds and the stage record for the bank window
// no dependencies; imported by the bank window top level
package brw_pkg;

    localparam int BYTE_W = 8;
    localparam int OP_W   = 3;
    localparam int DATA_W = 16;

    localparam logic [OP_W-1:0] OP_READ_BYTE  = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE_BYTE = 3'd1;
    localparam logic [OP_W-1:0] OP_READ_WORD  = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE_WORD = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_BANK  = 3'd4;
    localparam logic [OP_W-1:0] OP_WRITE_BANK = 3'd5;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_BYTE,
        RD_WORD,
        RD_BANK
    } t_rd_kind;

    typedef struct packed {
        t_rd_kind          kind;
        logic              bank_ok;
        logic              odd;
        logic              last;
        logic              spill;
        logic [BYTE_W-1:0] spill_byte;
        logic [BYTE_W-1:0] bank;
    } t_s1;

endpackage

// ===== rtl/brw_ram.sv =====
// brw_ram: generic single-port synchronous ram with registered read
// no dependencies; used for the even and odd byte lanes of the bank store
module brw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/banked_rom_window.sv =====
// banked_rom_window: bank-switched byte window over a multi-bank store
// depends on brw_pkg and brw_ram (even and odd byte lanes)
//
//  channel  | valid    | stall    | payload
//  ---------+----------+----------+--------------------------------------------
//  in       | i_valid  | o_stall  | i_operation, i_bus_address, i_write_value
//  out      | o_valid  | i_stall  | o_read_value, o_spill, o_spill_byte
//  cfg      | i_cfg_we | -        | i_cfg_wdata (flash write enable)
//
// one transaction per cycle while o_stall is low; a result is registered first by
// the synchronous ram read of both byte lanes, then by the output register
// writes land in the ram at the accepting edge, so the next transaction sees them
// after reset the store is cleared one lane row per cycle, all 2**(bank bits + offset
// bits - 1) rows (131072 with the default sizes), with o_stall high
// an output stall backs up through the read stage into o_stall
module banked_rom_window
    import brw_pkg::*;
#(
    parameter int BANK_COUNT = 32,
    parameter int BANK_BYTES = 8192
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [DATA_W-1:0] i_bus_address,
    input  logic [DATA_W-1:0] i_write_value,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [DATA_W-1:0] o_read_value,
    output logic              o_spill,
    output logic [BYTE_W-1:0] o_spill_byte
);

    localparam int OFF_AW    = $clog2(BANK_BYTES);
    localparam int BANK_AW   = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
    localparam int HALF_AW   = OFF_AW - 1;
    localparam int RAM_AW    = BANK_AW + HALF_AW;
    localparam int RAM_DEPTH = 2 ** RAM_AW;

    logic              r_fwe;
    logic [BYTE_W-1:0] r_bank;
    logic [BYTE_W-1:0] n_bank;
    logic              r_clearing;
    logic [RAM_AW-1:0] r_clr_addr;
    logic              r_s1_valid;
    t_s1               r_s1;
    t_s1               n_s1;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_rd;
    logic              r_out_spill;
    logic [BYTE_W-1:0] r_out_sbyte;

    logic              accept;
    logic              s1_move;
    logic [OFF_AW-1:0] offset;
    logic [HALF_AW-1:0] half;
    logic [HALF_AW-1:0] half_p1;
    logic              odd;
    logic              last;
    logic              bank_ok;
    logic              wr_ok;
    logic [BYTE_W-1:0] lo_in;
    logic [BYTE_W-1:0] hi_in;

    logic              even_we, odd_we, ram_re;
    logic [RAM_AW-1:0] even_addr, odd_addr;
    logic [BYTE_W-1:0] even_wdata, odd_wdata;
    logic [BYTE_W-1:0] even_rdata, odd_rdata;
    logic [BYTE_W-1:0] lo_q, hi_q;
    logic [DATA_W-1:0] s1_rd;

    // handshake
    assign s1_move = r_s1_valid && !(r_out_valid && i_stall);
    assign o_stall = r_clearing || (r_s1_valid && !s1_move);
    assign accept  = i_valid && !o_stall;

    // address split into even and odd byte lanes
    assign offset  = i_bus_address[OFF_AW-1:0];
    assign half    = offset[OFF_AW-1:1];
    assign half_p1 = half + 1'b1;
    assign odd     = offset[0];
    assign last    = &offset;
    assign bank_ok = {1'b0, r_bank} < 9'(BANK_COUNT);
    assign wr_ok   = r_fwe && bank_ok;
    assign lo_in   = i_write_value[BYTE_W-1:0];
    assign hi_in   = i_write_value[DATA_W-1:BYTE_W];

    always_comb begin
        n_bank     = r_bank;
        n_s1       = '0;
        n_s1.kind  = RD_NONE;
        n_s1.bank_ok = bank_ok;
        n_s1.odd   = odd;
        n_s1.last  = last;
        n_s1.bank  = r_bank;
        even_we    = 1'b0;
        odd_we     = 1'b0;
        ram_re     = 1'b0;
        even_addr  = {r_bank[BANK_AW-1:0], (odd ? half_p1 : half)};
        odd_addr   = {r_bank[BANK_AW-1:0], half};
        even_wdata = odd ? hi_in : lo_in;
        odd_wdata  = odd ? lo_in : hi_in;
        if (r_clearing) begin
            even_we    = 1'b1;
            odd_we     = 1'b1;
            even_addr  = r_clr_addr;
            odd_addr   = r_clr_addr;
            even_wdata = '0;
            odd_wdata  = '0;
        end else if (accept) begin
            case (i_operation)
                OP_READ_BYTE: begin
                    n_s1.kind = RD_BYTE;
                    ram_re    = 1'b1;
                end
                OP_WRITE_BYTE: begin
                    even_we = wr_ok && !odd;
                    odd_we  = wr_ok && odd;
                end
                OP_READ_WORD: begin
                    n_s1.kind  = RD_WORD;
                    n_s1.spill = bank_ok && last;
                    ram_re     = 1'b1;
                end
                OP_WRITE_WORD: begin
                    // low byte goes to its own lane, high byte to the other unless at the edge
                    even_we = wr_ok && (!odd || !last);
                    odd_we  = wr_ok;
                    if (wr_ok && last) begin
                        n_s1.spill      = 1'b1;
                        n_s1.spill_byte = hi_in;
                    end
                end
                OP_READ_BANK: begin
                    n_s1.kind = RD_BANK;
                end
                OP_WRITE_BANK: begin
                    n_bank = lo_in;
                end
                default: begin
                    n_s1.kind = RD_NONE;
                end
            endcase
        end
    end

    brw_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_even (
        .i_clk   (i_clk),
        .i_we    (even_we),
        .i_re    (ram_re),
        .i_addr  (even_addr),
        .i_wdata (even_wdata),
        .o_rdata (even_rdata)
    );

    brw_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_odd (
        .i_clk   (i_clk),
        .i_we    (odd_we),
        .i_re    (ram_re),
        .i_addr  (odd_addr),
        .i_wdata (odd_wdata),
        .o_rdata (odd_rdata)
    );

    // read stage: put the lane bytes back in address order
    assign lo_q = r_s1.odd ? odd_rdata : even_rdata;
    assign hi_q = r_s1.odd ? even_rdata : odd_rdata;

    always_comb begin
        case (r_s1.kind)
            RD_BYTE: s1_rd = r_s1.bank_ok ? {{BYTE_W{1'b0}}, lo_q} : '0;
            RD_WORD: begin
                if (!r_s1.bank_ok) begin
                    s1_rd = '0;
                end else if (r_s1.last) begin
                    s1_rd = {{BYTE_W{1'b0}}, lo_q};
                end else begin
                    s1_rd = {hi_q, lo_q};
                end
            end
            RD_BANK: s1_rd = {{BYTE_W{1'b0}}, r_s1.bank};
            default: s1_rd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwe       <= 1'b0;
            r_bank      <= '0;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fwe <= i_cfg_wdata;
            end
            r_bank <= n_bank;
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    r_clearing <= 1'b0;
                end
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
        if (s1_move) begin
            r_out_rd    <= s1_rd;
            r_out_spill <= r_s1.spill;
            r_out_sbyte <= r_s1.spill_byte;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_value = r_out_rd;
    assign o_spill      = r_out_spill;
    assign o_spill_byte = r_out_sbyte;

endmodule

// ===== rtl/brw_checker.sv =====
// brw_checker: port-level checks for the bank window, bound to the top level
// depends only on the ports of banked_rom_window
module brw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_read_value,
    input logic        o_spill,
    input logic [7:0]  o_spill_byte
);

    // reset starts the store clearing sweep and empties the output
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_stall && !o_valid))
        else $error("reset did not stall input and empty output");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_read_value)
            && $stable(o_spill) && $stable(o_spill_byte)))
        else $error("stalled result changed");

    // spill byte only travels with a spill
    a_sbyte_spill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_spill_byte != 8'd0)) |-> o_spill)
        else $error("spill byte without spill");

    // a spilled transaction, word read or word write, carries no high byte
    a_spill_high_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_spill) |-> (o_read_value[15:8] == 8'd0))
        else $error("spilled transaction has a high byte");

endmodule

bind banked_rom_window brw_checker u_brw_checker (.*);

// ===== tb/banked_rom_window_tb.sv =====
`timescale 1ns / 100ps
// banked_rom_window_tb: directed and random window transactions with random idle gaps
// on both channels, each result checked against a byte-level shadow of the bank store or a listed value
// depends on brw_pkg and the banked_rom_window rtl
module banked_rom_window_tb;
    import brw_pkg::*;

    localparam int BANK_COUNT = 32;
    localparam int BANK_BYTES = 8192;
    localparam int OFF_W = 13;
    localparam int MAX_REPORTS = 200;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
    localparam logic [OFF_W-1:0] LAST_OFF = 13'h1FFF;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic              spill;
        logic [BYTE_W-1:0] spill_byte;
    } t_result;

    typedef struct {
        logic              fwe;
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] addr;
        logic [DATA_W-1:0] wval;
        logic              known;
        t_result           want;
    } t_row;

    localparam t_result NO_DATA = '{16'h0000, 1'b0, 8'h00};

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_wdata = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [OP_W-1:0]   i_operation = '0;
    logic [DATA_W-1:0] i_bus_address = '0;
    logic [DATA_W-1:0] i_write_value = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [DATA_W-1:0] o_read_value;
    logic              o_spill;
    logic [BYTE_W-1:0] o_spill_byte;

    bit [BYTE_W-1:0] shadow_rom [BANK_COUNT*BANK_BYTES];
    logic [BYTE_W-1:0] shadow_bank = '0;
    logic shadow_fwe = 1'b0;
    t_result expected_reads[$];
    int mismatch_count = 0;
    int idle_pct = 37;

    banked_rom_window #(
        .BANK_COUNT(BANK_COUNT),
        .BANK_BYTES(BANK_BYTES)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_bus_address(i_bus_address),
        .i_write_value(i_write_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_value (o_read_value),
        .o_spill      (o_spill),
        .o_spill_byte (o_spill_byte)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_result window_access(logic [OP_W-1:0] op, logic [DATA_W-1:0] addr,
                                              logic [DATA_W-1:0] wval);
        t_result r;
        int off;
        int base;
        logic bank_ok;
        logic wr_ok;
        r = NO_DATA;
        off = int'(addr[OFF_W-1:0]);
        bank_ok = int'(shadow_bank) < BANK_COUNT;
        wr_ok = bank_ok && shadow_fwe;
        base = int'(shadow_bank) * BANK_BYTES;
        case (op)
            OP_READ_BYTE: begin
                if (bank_ok) r.read_value = {8'h00, shadow_rom[base + off]};
            end
            OP_WRITE_BYTE: begin
                if (wr_ok) shadow_rom[base + off] = wval[7:0];
            end
            OP_READ_WORD: begin
                if (bank_ok) begin
                    r.read_value[7:0] = shadow_rom[base + off];
                    if (off == int'(LAST_OFF)) r.spill = 1'b1;
                    else r.read_value[15:8] = shadow_rom[base + off + 1];
                end
            end
            OP_WRITE_WORD: begin
                if (wr_ok) begin
                    shadow_rom[base + off] = wval[7:0];
                    if (off == int'(LAST_OFF)) begin
                        r.spill = 1'b1;
                        r.spill_byte = wval[15:8];
                    end else begin
                        shadow_rom[base + off + 1] = wval[15:8];
                    end
                end
            end
            OP_READ_BANK: r.read_value = {8'h00, shadow_bank};
            OP_WRITE_BANK: shadow_bank = wval[7:0];
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_reads.size() == 0) begin
                report_mismatch("unexpected transaction", o_read_value, 16'h0000);
            end else begin
                want = expected_reads.pop_front();
                if (o_read_value !== want.read_value)
                    report_mismatch("read_value", o_read_value, want.read_value);
                if (o_spill !== want.spill)
                    report_mismatch("spill", 16'(o_spill), 16'(want.spill));
                if (o_spill_byte !== want.spill_byte)
                    report_mismatch("spill_byte", 16'(o_spill_byte), 16'(want.spill_byte));
            end
        end
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    task automatic send_access(logic [OP_W-1:0] op, logic [DATA_W-1:0] addr,
                               logic [DATA_W-1:0] wval, logic known, t_result want);
        t_result pred;
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_bus_address <= addr;
        i_write_value <= wval;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pred = window_access(op, addr, wval);
        expected_reads.push_back(known ? want : pred);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (expected_reads.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_flash(logic fwe);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= fwe;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_fwe = fwe;
        @(posedge i_clk);
    endtask

    task automatic random_access;
        logic [OP_W-1:0] op;
        logic [DATA_W-1:0] addr;
        logic [DATA_W-1:0] wval;
        int pick;
        pick = $urandom_range(0, 99);
        addr = 16'($urandom);
        wval = 16'($urandom);
        if (pick < 6) begin
            op = OP_WRITE_BANK;
            if ($urandom_range(0, 99) < 12) wval[7:0] = 8'($urandom_range(BANK_COUNT, 255));
            else if ($urandom_range(0, 99) < 60) wval[7:0] = 8'($urandom_range(0, 3));
            else wval[7:0] = 8'($urandom_range(0, BANK_COUNT - 1));
        end else if (pick < 10) begin
            op = OP_READ_BANK;
        end else if (pick < 11) begin
            op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
        end else begin
            op = pick < 30 ? OP_READ_BYTE : pick < 50 ? OP_WRITE_BYTE :
                 pick < 75 ? OP_READ_WORD : OP_WRITE_WORD;
            // favor the window edge and a small hot region so reads see written data
            case ($urandom_range(0, 9))
                0, 1, 2: addr[OFF_W-1:0] = LAST_OFF;
                3, 4: addr[OFF_W-1:0] = LAST_OFF - 13'd1;
                5, 6, 7: addr[OFF_W-1:0] = 13'($urandom_range(0, 15));
                default: ;
            endcase
        end
        send_access(op, addr, wval, 1'b0, NO_DATA);
    endtask

    initial begin
        t_row rows[$];
        int n;
        rows.push_back('{1'b0, OP_READ_BANK, 16'h0000, 16'h0000, 1'b1, NO_DATA});
        rows.push_back('{1'b0, OP_READ_WORD, 16'hFFFF, 16'h0000, 1'b1, '{16'h0000, 1'b1, 8'h00}});
        rows.push_back('{1'b0, OP_WRITE_WORD, 16'h0000, 16'hBEEF, 1'b1, NO_DATA});
        rows.push_back('{1'b0, OP_WRITE_WORD, 16'h1FFF, 16'hA55A, 1'b1, NO_DATA});
        rows.push_back('{1'b0, OP_READ_WORD, 16'h0000, 16'h0000, 1'b1, NO_DATA});
        rows.push_back('{1'b0, OP_SPARE_6, 16'hFFFF, 16'hFFFF, 1'b1, NO_DATA});
        rows.push_back('{1'b0, OP_SPARE_7, 16'h5A5A, 16'hFFFF, 1'b1, NO_DATA});
        rows.push_back('{1'b1, OP_WRITE_WORD, 16'h0000, 16'hBEEF, 1'b1, NO_DATA});
        rows.push_back('{1'b1, OP_READ_WORD, 16'h0000, 16'h0000, 1'b0, NO_DATA});
        rows.push_back('{1'b1, OP_WRITE_BYTE, 16'hE001, 16'hFF12, 1'b1, NO_DATA});
        rows.push_back('{1'b1, OP_READ_WORD, 16'hE000, 16'h0000, 1'b0, NO_DATA});
        rows.push_back('{1'b1, OP_READ_BYTE, 16'h2001, 16'h0000, 1'b0, NO_DATA});
        rows.push_back('{1'b1, OP_WRITE_WORD, 16'hFFFF, 16'hA55A, 1'b1, '{16'h0000, 1'b1, 8'hA5}});
        rows.push_back('{1'b1, OP_READ_WORD, 16'h1FFF, 16'h0000, 1'b0, NO_DATA});
        rows.push_back('{1'b1, OP_READ_BYTE, 16'h1FFF, 16'h0000, 1'b0, NO_DATA});
        rows.push_back('{1'b1, OP_WRITE_BANK, 16'h1234, 16'hFF1F, 1'b1, NO_DATA});
        rows.push_back('{1'b1, OP_WRITE_WORD, 16'h1FFE, 16'hFFFF, 1'b1, NO_DATA});
        rows.push_back('{1'b1, OP_READ_WORD, 16'h1FFE, 16'h0000, 1'b0, NO_DATA});
        rows.push_back('{1'b1, OP_READ_BANK, 16'hFFFF, 16'h0000, 1'b1, '{16'h001F, 1'b0, 8'h00}});
        rows.push_back('{1'b1, OP_WRITE_BANK, 16'h0000, 16'h0020, 1'b1, NO_DATA});
        rows.push_back('{1'b1, OP_READ_BYTE, 16'h0000, 16'h0000, 1'b1, NO_DATA});
        rows.push_back('{1'b1, OP_WRITE_WORD, 16'h1FFF, 16'h1234, 1'b1, NO_DATA});
        rows.push_back('{1'b1, OP_READ_WORD, 16'h1FFF, 16'h0000, 1'b1, NO_DATA});
        rows.push_back('{1'b1, OP_READ_BANK, 16'h0000, 16'h0000, 1'b1, '{16'h0020, 1'b0, 8'h00}});
        rows.push_back('{1'b1, OP_WRITE_BANK, 16'h0000, 16'hFFFF, 1'b1, NO_DATA});
        rows.push_back('{1'b1, OP_READ_BANK, 16'h0000, 16'h0000, 1'b1, '{16'h00FF, 1'b0, 8'h00}});
        rows.push_back('{1'b1, OP_WRITE_BANK, 16'h0000, 16'h0000, 1'b1, NO_DATA});
        rows.push_back('{1'b1, OP_READ_WORD, 16'h1FFF, 16'h0000, 1'b0, NO_DATA});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            if (rows[k].fwe !== shadow_fwe) set_flash(rows[k].fwe);
            send_access(rows[k].op, rows[k].addr, rows[k].wval, rows[k].known, rows[k].want);
        end

        for (int ph = 0; ph < 6; ph++) begin
            set_flash(!(ph == 1 || ph == 4));
            // one phase runs with no idling on either side
            idle_pct = (ph == 3) ? 0 : 37;
            repeat (320) random_access();
        end

        i_valid <= 1'b0;
        for (n = 0; n < 2000 && expected_reads.size() != 0; n++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (expected_reads.size() != 0) begin
            $display("%0d expected transactions never arrived", expected_reads.size());
            mismatch_count += expected_reads.size();
        end
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // covers the post-reset clearing pass plus the stalled traffic several times over
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
